// File: rtl/core/scfm_pkg.sv
package scfm_pkg;

  // Field and register widths.
  localparam int OP_W       = 2;
  localparam int SYM_W      = 8;
  localparam int VAL_W      = 17;
  localparam int STATUS_W   = 2;
  localparam int CNT_W      = 9;
  localparam int LOG2_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_W-1:0] OP_DECODE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_SYM   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LOAD_PAST = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_SUM_OVER  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LOG2   = 1'd1;

  localparam logic [CNT_W-1:0]  SYMBOL_COUNT_RST = 9'd256;
  localparam logic [LOG2_W-1:0] TOTAL_LOG2_RST   = 5'd16;

  // Control part of a search token travelling down the cell chain.
  typedef struct packed {
    logic valid;
    logic is_dec;
    logic done;
  } tok_ctl_t;

endpackage

// File: rtl/core/scfm_cell.sv
module scfm_cell
  import scfm_pkg::*;
#(
  parameter int Index = 0,
  parameter int SumW  = 17,
  parameter int IdxW  = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Token injection, broadcast to every cell.
  input  tok_ctl_t         inj_ctl_i,
  input  logic [CNT_W-1:0] inj_idx_i,
  input  logic [SumW-1:0]  inj_key_i,
  input  logic [SumW-1:0]  inj_a_i,
  // Token from the cell above.
  input  tok_ctl_t         up_ctl_i,
  input  logic [SumW-1:0]  up_key_i,
  input  logic [SumW-1:0]  up_a_i,
  input  logic [IdxW-1:0]  up_found_i,
  // Table write, broadcast to every cell.
  input  logic             wr_en_i,
  input  logic [CNT_W-1:0] wr_idx_i,
  input  logic [SumW-1:0]  wr_data_i,
  // Token handed to the cell below.
  output tok_ctl_t         dn_ctl_o,
  output logic [SumW-1:0]  dn_key_o,
  output logic [SumW-1:0]  dn_a_o,
  output logic [IdxW-1:0]  dn_found_o
);

  logic [SumW-1:0] cum_q;
  tok_ctl_t        ctl_q, ctl_d;
  logic [SumW-1:0] key_q, key_d;
  logic [SumW-1:0] a_q, a_d;
  logic [IdxW-1:0] found_q, found_d;
  logic            sel_inj;
  logic            hit;

  assign sel_inj = inj_ctl_i.valid && (int'(inj_idx_i) == Index);

  always_comb begin
    if (sel_inj) begin
      ctl_d   = inj_ctl_i;
      key_d   = inj_key_i;
      a_d     = inj_a_i;
      found_d = '0;
    end else begin
      ctl_d   = up_ctl_i;
      key_d   = up_key_i;
      a_d     = up_a_i;
      found_d = up_found_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    a_q     <= a_d;
    found_q <= found_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (int'(wr_idx_i) == Index)) begin
      cum_q <= wr_data_i;
    end
  end

  // A decode stops at the first bound from the top that is not above the
  // target, or at symbol zero; an encode stops at its own symbol.
  assign hit = ctl_q.is_dec ? ((Index == 0) || (key_q >= cum_q))
                            : (key_q == SumW'(Index));

  // Before the hit the token carries the bound of the cell above as the
  // upper edge; after it, the key holds the low bound and a the width.
  always_comb begin
    dn_ctl_o   = ctl_q;
    dn_key_o   = key_q;
    dn_a_o     = a_q;
    dn_found_o = found_q;
    if (ctl_q.valid && !ctl_q.done) begin
      if (hit) begin
        dn_ctl_o.done = 1'b1;
        dn_key_o      = cum_q;
        dn_a_o        = (a_q >= cum_q) ? (a_q - cum_q) : '0;
        dn_found_o    = IdxW'(Index);
      end else begin
        dn_a_o = cum_q;
      end
    end
  end

endmodule

// File: rtl/core/static_cumulative_frequency_model_core.sv
// Static frequency model for a range coder. Load requests write symbol
// frequencies in order (first restarts at symbol zero); each load stores the
// running sum as the next symbol's low bound and answers in the cycle after
// it is taken, as do unused op codes and encode requests for a symbol outside
// the alphabet. The table lives in a row of cells, one symbol per cell, and a
// query travels down that row as a token, one cell per clock. An encode request
// for symbol s enters at cell s+1; for the last symbol it enters at that
// symbol's own cell. A decode request enters at the last symbol. Only one query
// is in the row at a time, so the next request is taken once the result has
// left the row. A result waiting at the output holds off the next request until
// it is taken; a search result that finds the output occupied waits in a buffer
// for as long as the output stalls.
module static_cumulative_frequency_model_core
  import scfm_pkg::*;
#(
  parameter int MAX_SYMBOLS    = 256,
  parameter int MAX_TOTAL_LOG2 = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [OP_W-1:0]       op_i,
  input  logic                  first_i,
  input  logic [SYM_W-1:0]      symbol_i,
  input  logic [VAL_W-1:0]      value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SYM_W-1:0]      found_symbol_o,
  output logic [VAL_W-1:0]      frequency_o,
  output logic [VAL_W-1:0]      cum_low_o,
  output logic [STATUS_W-1:0]   status_o
);

  localparam int SumW = (MAX_TOTAL_LOG2 + 1 > VAL_W) ? MAX_TOTAL_LOG2 + 1 : VAL_W;
  localparam int IdxW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q;
  logic [LOG2_W-1:0] log2_q;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic [SumW-1:0]   sum_q, sum_d;

  logic [CNT_W-1:0]  eff_cnt;
  logic [LOG2_W-1:0] eff_log2;
  logic [SumW-1:0]   total;

  logic              in_acc;
  logic              out_free;
  logic              start_chain;
  logic              ld_ok;
  logic              ld_acc;
  logic [CNT_W-1:0]  ptr_eff;
  logic [SumW-1:0]   sum_eff;
  logic [SumW:0]     sum_ext;
  logic              sum_over;
  logic              sym_bad;
  logic [CNT_W-1:0]  sym_p1;

  logic [SYM_W-1:0]    imm_found;
  logic [VAL_W-1:0]    imm_freq;
  logic [VAL_W-1:0]    imm_low;
  logic [STATUS_W-1:0] imm_status;

  tok_ctl_t          inj_ctl;
  logic [CNT_W-1:0]  inj_idx;
  logic [SumW-1:0]   inj_key;

  tok_ctl_t          dn_ctl   [MAX_SYMBOLS];
  logic [SumW-1:0]   dn_key   [MAX_SYMBOLS];
  logic [SumW-1:0]   dn_a     [MAX_SYMBOLS];
  logic [IdxW-1:0]   dn_found [MAX_SYMBOLS];
  logic [MAX_SYMBOLS-1:0] tok_vld;

  logic              exit_valid;
  logic [SYM_W-1:0]  exit_found;
  logic [VAL_W-1:0]  exit_freq;
  logic [VAL_W-1:0]  exit_low;

  logic              xbuf_load;
  logic [SYM_W-1:0]  xbuf_found_q;
  logic [VAL_W-1:0]  xbuf_freq_q;
  logic [VAL_W-1:0]  xbuf_low_q;

  logic                out_valid_q;
  logic                out_load;
  logic [SYM_W-1:0]    out_found_q, out_found_d;
  logic [VAL_W-1:0]    out_freq_q, out_freq_d;
  logic [VAL_W-1:0]    out_low_q, out_low_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;

  // Configuration.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= SYMBOL_COUNT_RST;
      log2_q <= TOTAL_LOG2_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SYMBOL_COUNT: cnt_q  <= cfg_data_i[CNT_W-1:0];
        REG_TOTAL_LOG2:   log2_q <= cfg_data_i[LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cnt_q < CNT_W'(2)) begin
      eff_cnt = CNT_W'(2);
    end else if (int'(cnt_q) > MAX_SYMBOLS) begin
      eff_cnt = CNT_W'(MAX_SYMBOLS);
    end else begin
      eff_cnt = cnt_q;
    end
    if (log2_q < LOG2_W'(1)) begin
      eff_log2 = LOG2_W'(1);
    end else if (int'(log2_q) > MAX_TOTAL_LOG2) begin
      eff_log2 = LOG2_W'(MAX_TOTAL_LOG2);
    end else begin
      eff_log2 = log2_q;
    end
  end

  assign total = SumW'(1) << eff_log2;

  // Request decode.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  assign ptr_eff  = first_i ? '0 : ptr_q;
  assign sum_eff  = first_i ? '0 : sum_q;
  assign ld_ok    = ptr_eff < eff_cnt;
  assign sum_ext  = {1'b0, sum_eff} + (SumW + 1)'(value_i);
  assign sum_over = sum_ext > {1'b0, total};
  assign sym_bad  = CNT_W'(symbol_i) >= eff_cnt;
  assign sym_p1   = CNT_W'(symbol_i) + CNT_W'(1);

  always_comb begin
    start_chain = 1'b0;
    ld_acc      = 1'b0;
    imm_found   = '0;
    imm_freq    = '0;
    imm_low     = '0;
    imm_status  = STATUS_OK;
    case (op_i)
      OP_LOAD: begin
        if (ld_ok) begin
          ld_acc     = 1'b1;
          imm_found  = SYM_W'(ptr_eff);
          imm_freq   = value_i;
          imm_low    = VAL_W'(sum_eff);
          imm_status = sum_over ? STATUS_SUM_OVER : STATUS_OK;
        end else begin
          imm_status = STATUS_LOAD_PAST;
        end
      end
      OP_ENCODE: begin
        imm_found = symbol_i;
        if (sym_bad) begin
          imm_status = STATUS_BAD_SYM;
        end else begin
          start_chain = 1'b1;
        end
      end
      OP_DECODE: start_chain = 1'b1;
      default: ;
    endcase
  end

  // Loading pointer and running sum.
  assign ptr_d = ptr_eff + CNT_W'(1);
  assign sum_d = sum_over ? total : sum_ext[SumW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      sum_q <= '0;
    end else if (in_acc && ld_acc) begin
      ptr_q <= ptr_d;
      sum_q <= sum_d;
    end
  end

  // Token injection: a decode enters at the last symbol, an encode just above its
  // own symbol (the last symbol at its own cell) so that it picks up the upper bound.
  assign inj_ctl.valid  = in_acc && start_chain;
  assign inj_ctl.is_dec = (op_i == OP_DECODE);
  assign inj_ctl.done   = 1'b0;
  assign inj_key        = (op_i == OP_DECODE) ? SumW'(value_i) : SumW'(symbol_i);
  assign inj_idx        = ((op_i == OP_DECODE) || (sym_p1 >= eff_cnt))
                          ? (eff_cnt - CNT_W'(1)) : sym_p1;

  for (genvar i = 0; i < MAX_SYMBOLS; i++) begin : g_cell
    tok_ctl_t        up_ctl;
    logic [SumW-1:0] up_key;
    logic [SumW-1:0] up_a;
    logic [IdxW-1:0] up_found;

    if (i == MAX_SYMBOLS - 1) begin : g_top
      assign up_ctl   = '0;
      assign up_key   = '0;
      assign up_a     = '0;
      assign up_found = '0;
    end else begin : g_mid
      assign up_ctl   = dn_ctl[i+1];
      assign up_key   = dn_key[i+1];
      assign up_a     = dn_a[i+1];
      assign up_found = dn_found[i+1];
    end

    scfm_cell #(
      .Index (i),
      .SumW  (SumW),
      .IdxW  (IdxW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .inj_ctl_i  (inj_ctl),
      .inj_idx_i  (inj_idx),
      .inj_key_i  (inj_key),
      .inj_a_i    (total),
      .up_ctl_i   (up_ctl),
      .up_key_i   (up_key),
      .up_a_i     (up_a),
      .up_found_i (up_found),
      .wr_en_i    (in_acc && ld_acc),
      .wr_idx_i   (ptr_eff),
      .wr_data_i  (sum_eff),
      .dn_ctl_o   (dn_ctl[i]),
      .dn_key_o   (dn_key[i]),
      .dn_a_o     (dn_a[i]),
      .dn_found_o (dn_found[i])
    );

    assign tok_vld[i] = dn_ctl[i].valid;
  end

  assign exit_valid = dn_ctl[0].valid;
  assign exit_found = SYM_W'(dn_found[0]);
  assign exit_freq  = VAL_W'(dn_a[0]);
  assign exit_low   = VAL_W'(dn_key[0]);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (inj_ctl.valid) begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (exit_valid) begin
          state_d = out_free ? S_IDLE : S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A search result that finds the output still occupied waits here.
  assign xbuf_load = exit_valid && !out_free;

  always_ff @(posedge clk_i) begin
    if (xbuf_load) begin
      xbuf_found_q <= exit_found;
      xbuf_freq_q  <= exit_freq;
      xbuf_low_q   <= exit_low;
    end
  end

  // Output register.
  always_comb begin
    out_load     = 1'b0;
    out_found_d  = imm_found;
    out_freq_d   = imm_freq;
    out_low_d    = imm_low;
    out_status_d = imm_status;
    if (in_acc && !start_chain) begin
      out_load = 1'b1;
    end else if (exit_valid && out_free) begin
      out_load     = 1'b1;
      out_found_d  = exit_found;
      out_freq_d   = exit_freq;
      out_low_d    = exit_low;
      out_status_d = STATUS_OK;
    end else if ((state_q == S_DRAIN) && out_free) begin
      out_load     = 1'b1;
      out_found_d  = xbuf_found_q;
      out_freq_d   = xbuf_freq_q;
      out_low_d    = xbuf_low_q;
      out_status_d = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_found_q  <= out_found_d;
      out_freq_q   <= out_freq_d;
      out_low_q    <= out_low_d;
      out_status_q <= out_status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_symbol_o = out_found_q;
  assign frequency_o    = out_freq_q;
  assign cum_low_o      = out_low_q;
  assign status_o       = out_status_q;

`ifndef SYNTHESIS
  a_one_token_in_search : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) == $onehot(tok_vld))
    else $error("token count in the cell row does not match the search state");

  a_drain_holds_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> out_valid_q)
    else $error("result waiting in the buffer while the output is empty");

  a_blocked_exit_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exit_valid && !out_free) |=> (state_q == S_DRAIN))
    else $error("search result leaving the row was not buffered");

  a_pointer_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(ptr_q) <= MAX_SYMBOLS)
    else $error("load pointer beyond the table");

  a_sum_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= (SumW'(1) << MAX_TOTAL_LOG2))
    else $error("running sum above the largest total");
`endif

endmodule

// File: test/tb_static_cumulative_frequency_model_core.sv
module tb_static_cumulative_frequency_model_core;
  import scfm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SYMBOLS    = 256;
  localparam int MAX_TOTAL_LOG2 = 16;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             first;
    logic [SYM_W-1:0] symbol;
    logic [VAL_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [SYM_W-1:0]    found_symbol;
    logic [VAL_W-1:0]    frequency;
    logic [VAL_W-1:0]    cum_low;
    logic [STATUS_W-1:0] status;
  } interval_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [OP_W-1:0]       op_i;
  logic                  first_i;
  logic [SYM_W-1:0]      symbol_i;
  logic [VAL_W-1:0]      value_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [SYM_W-1:0]      found_symbol_o;
  logic [VAL_W-1:0]      frequency_o;
  logic [VAL_W-1:0]      cum_low_o;
  logic [STATUS_W-1:0]   status_o;

  static_cumulative_frequency_model_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .first_i        (first_i),
    .symbol_i       (symbol_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_symbol_o (found_symbol_o),
    .frequency_o    (frequency_o),
    .cum_low_o      (cum_low_o),
    .status_o       (status_o)
  );

  // Predicted state of the frequency model.
  logic [VAL_W-1:0]  cum_tbl [MAX_SYMBOLS];
  bit                written [MAX_SYMBOLS];
  int                load_ptr = 0;
  int unsigned       run_sum  = 0;
  logic [CNT_W-1:0]  cfg_count = SYMBOL_COUNT_RST;
  logic [LOG2_W-1:0] cfg_log2  = TOTAL_LOG2_RST;

  interval_t expected_intervals [$];
  int        mismatches = 0;
  int        idle_pct   = 0;
  int        hold_left  = 0;
  bit        calm       = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int active_count();
    if (cfg_count < 2) return 2;
    if (cfg_count > MAX_SYMBOLS) return MAX_SYMBOLS;
    return int'(cfg_count);
  endfunction

  function automatic int unsigned active_total();
    if (cfg_log2 < 1) return 2;
    if (cfg_log2 > MAX_TOTAL_LOG2) return 1 << MAX_TOTAL_LOG2;
    return 1 << cfg_log2;
  endfunction

  // Queries may only be issued once every symbol in use has a stored bound.
  function automatic bit table_filled();
    for (int i = 0; i < active_count(); i++) begin
      if (!written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int unsigned interval_width(int s, int count);
    int unsigned lo;
    int unsigned hi;
    lo = 32'(cum_tbl[s]);
    hi = (s + 1 < count) ? int'(cum_tbl[s + 1]) : active_total();
    return (hi >= lo) ? hi - lo : 0;
  endfunction

  function automatic interval_t predict_interval(request_t rq);
    interval_t   r;
    int          count;
    int          s;
    int unsigned total;
    int unsigned sum;
    r        = '0;
    r.status = STATUS_OK;
    count    = active_count();
    total    = active_total();
    case (rq.op)
      OP_LOAD: begin
        if (rq.first) begin
          load_ptr = 0;
          run_sum  = 0;
        end
        if (load_ptr >= count) begin
          r.status = STATUS_LOAD_PAST;
        end else begin
          sum               = run_sum + rq.value;
          cum_tbl[load_ptr] = VAL_W'(run_sum);
          written[load_ptr] = 1'b1;
          r.found_symbol    = SYM_W'(load_ptr);
          r.frequency       = rq.value;
          r.cum_low         = VAL_W'(run_sum);
          if (sum > total) begin
            sum      = total;
            r.status = STATUS_SUM_OVER;
          end
          run_sum  = sum;
          load_ptr = load_ptr + 1;
        end
      end
      OP_ENCODE: begin
        r.found_symbol = rq.symbol;
        if (int'(rq.symbol) >= count) begin
          r.status = STATUS_BAD_SYM;
        end else begin
          r.frequency = VAL_W'(interval_width(int'(rq.symbol), count));
          r.cum_low   = cum_tbl[rq.symbol];
        end
      end
      OP_DECODE: begin
        // Search downwards for the highest symbol whose bound is not above the target.
        s = count - 1;
        while (s > 0 && rq.value < cum_tbl[s]) s--;
        r.found_symbol = SYM_W'(s);
        r.frequency    = VAL_W'(interval_width(s, count));
        r.cum_low      = cum_tbl[s];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : scoreboard
    interval_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_SYMBOL_COUNT) cfg_count = cfg_data_i;
        else cfg_log2 = cfg_data_i[LOG2_W-1:0];
      end
      if (in_valid_i && in_ready_o) begin
        expected_intervals.push_back(predict_interval({op_i, first_i, symbol_i, value_i}));
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_intervals.size() == 0) begin
          $error("result returned with no request outstanding");
          mismatches++;
        end else begin
          want = expected_intervals.pop_front();
          check_field("found_symbol", 32'(want.found_symbol), 32'(found_symbol_o));
          check_field("frequency", 32'(want.frequency), 32'(frequency_o));
          check_field("cum_low", 32'(want.cum_low), 32'(cum_low_o));
          check_field("status", 32'(want.status), 32'(status_o));
        end
      end
    end
  end

  // Result side: random stall bursts, plus a long hold-off when one is asked for.
  initial begin : receiver
    int stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (calm) stall_left = 0;
      else if (stall_left == 0 && $urandom_range(0, 99) < idle_pct / 2)
        stall_left = $urandom_range(1, 19);
      out_ready_i <= (hold_left == 0 && stall_left == 0);
      if (hold_left > 0) hold_left--;
      if (stall_left > 0) stall_left--;
    end
  end

  function automatic request_t make_request(input logic [OP_W-1:0] op, input logic first,
                                            input logic [SYM_W-1:0] symbol,
                                            input logic [VAL_W-1:0] value);
    request_t rq;
    rq.op     = op;
    rq.first  = first;
    rq.symbol = symbol;
    rq.value  = value;
    return rq;
  endfunction

  function automatic request_t random_request();
    request_t    rq;
    int          count;
    int          pick;
    int unsigned total;
    int unsigned spread;
    count     = active_count();
    total     = active_total();
    spread    = total / count;
    rq.op     = OP_UNUSED;
    rq.first  = 1'($urandom_range(0, 1));
    rq.symbol = SYM_W'($urandom);
    rq.value  = VAL_W'($urandom);
    pick      = $urandom_range(0, 99);
    if (!table_filled()) pick = 80;
    if (pick < 35) begin
      rq.op = OP_DECODE;
      if (pick >= 4) rq.value = VAL_W'($urandom_range(0, total + 1));
    end else if (pick < 62) begin
      rq.op     = OP_ENCODE;
      rq.symbol = SYM_W'($urandom_range(0, count - 1));
    end else if (pick < 70) begin
      rq.op = OP_ENCODE;
    end else if (pick < 94) begin
      // Mostly carry on the current load sequence; now and then start a fresh one.
      rq.op    = OP_LOAD;
      rq.first = (pick >= 88) || (load_ptr >= count && pick >= 80);
      if (pick != 93) rq.value = VAL_W'($urandom_range(0, 2 * spread + 1));
    end
    return rq;
  endfunction

  // Every task below is entered just after a falling edge and leaves at one.
  task automatic send_request(input request_t rq);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= rq.op;
    first_i    <= rq.first;
    symbol_i   <= rq.symbol;
    value_i    <= rq.value;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_intervals.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] count_w,
                           input logic [CFG_DATA_W-1:0] log2_w);
    wait_idle();
    write_reg(REG_SYMBOL_COUNT, count_w);
    write_reg(REG_TOTAL_LOG2, log2_w);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_table();
    int unsigned spread;
    spread = active_total() / active_count();
    for (int i = 0; i < active_count(); i++) begin
      send_request(make_request(OP_LOAD, i == 0, SYM_W'($urandom),
                                VAL_W'($urandom_range(0, 2 * spread + 1))));
    end
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] count_w,
                           input logic [CFG_DATA_W-1:0] log2_w, input int n_random);
    configure(count_w, log2_w);
    if (calm || $urandom_range(0, 2) == 0) idle_pct = 0;
    else idle_pct = $urandom_range(5, 40);
    if (!table_filled() || active_count() <= 64) load_table();
    repeat (n_random) send_request(random_request());
  endtask

  task automatic test_directed();
    idle_pct = 25;
    // Reset settings: an unused op code and a load from the reset pointer.
    send_request(make_request(OP_UNUSED, 1'b1, 8'd255, 17'h1FFFF));
    send_request(make_request(OP_LOAD, 1'b0, 8'd0, 17'd5));
    configure(9'd4, 9'd4);
    send_request(make_request(OP_ENCODE, 1'b0, 8'd255, 17'd0));
    send_request(make_request(OP_ENCODE, 1'b1, 8'd4, 17'd0));
    send_request(make_request(OP_LOAD, 1'b1, 8'd0, 17'd3));
    send_request(make_request(OP_LOAD, 1'b0, 8'd0, 17'd5));
    send_request(make_request(OP_LOAD, 1'b0, 8'd0, 17'd0));
    // This fills the total exactly; the next load runs past the alphabet.
    send_request(make_request(OP_LOAD, 1'b0, 8'd0, 17'd8));
    send_request(make_request(OP_LOAD, 1'b0, 8'd0, 17'd1));
    send_request(make_request(OP_ENCODE, 1'b0, 8'd0, 17'd0));
    send_request(make_request(OP_ENCODE, 1'b0, 8'd2, 17'd0));
    send_request(make_request(OP_ENCODE, 1'b0, 8'd3, 17'd0));
    send_request(make_request(OP_DECODE, 1'b0, 8'd0, 17'd0));
    send_request(make_request(OP_DECODE, 1'b0, 8'd0, 17'd8));
    send_request(make_request(OP_DECODE, 1'b0, 8'd0, 17'd7));
    send_request(make_request(OP_DECODE, 1'b0, 8'd0, 17'd16));
    send_request(make_request(OP_DECODE, 1'b0, 8'd0, 17'h1FFFF));
    // Overrun the total; the last bound from the earlier table is left lower.
    send_request(make_request(OP_LOAD, 1'b1, 8'd0, 17'd10));
    send_request(make_request(OP_LOAD, 1'b0, 8'd0, 17'd10));
    send_request(make_request(OP_LOAD, 1'b0, 8'd0, 17'h1FFFF));
    send_request(make_request(OP_ENCODE, 1'b0, 8'd2, 17'd0));
    send_request(make_request(OP_DECODE, 1'b0, 8'd0, 17'd9));
    send_request(make_request(OP_DECODE, 1'b0, 8'd0, 17'd5));
    // Shrinking the total below the last bound leaves the last symbol empty.
    configure(9'd4, 9'd2);
    send_request(make_request(OP_ENCODE, 1'b0, 8'd3, 17'd0));
    send_request(make_request(OP_DECODE, 1'b0, 8'd0, 17'd3));
  endtask

  task automatic test_alphabet_extremes();
    run_phase(9'd2, 9'd1, 40);
    run_phase(9'd0, 9'd0, 30);
    run_phase(9'd1, 9'd17, 20);
    run_phase(9'd256, 9'd16, 100);
    run_phase(9'd511, 9'h1FF, 40);
    run_phase(9'd3, 9'd16, 30);
  endtask

  task automatic test_output_backpressure();
    run_phase(9'd8, 9'd10, 0);
    // The sender keeps offering requests while results are refused.
    hold_left = 300;
    repeat (16) send_request(random_request());
  endtask

  task automatic test_random_settings();
    logic [CFG_DATA_W-1:0] count_w;
    logic [CFG_DATA_W-1:0] log2_w;
    repeat (6) begin
      if ($urandom_range(0, 4) == 0) count_w = CFG_DATA_W'($urandom_range(17, 300));
      else count_w = CFG_DATA_W'($urandom_range(2, 16));
      if ($urandom_range(0, 9) == 0) log2_w = CFG_DATA_W'($urandom);
      else log2_w = CFG_DATA_W'($urandom_range(1, 16));
      run_phase(count_w, log2_w, 60);
    end
  endtask

  task automatic test_back_to_back();
    calm = 1'b1;
    run_phase(CFG_DATA_W'($urandom_range(2, 12)), CFG_DATA_W'($urandom_range(4, 16)), 80);
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    op_i        = '0;
    first_i     = 1'b0;
    symbol_i    = '0;
    value_i     = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_alphabet_extremes();
    test_output_backpressure();
    test_random_settings();
    test_back_to_back();
    wait_idle();
    repeat (260) @(negedge clk_i);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
